>>> sv/otsu_pkg.sv
package otsu_pkg;

	localparam int NUM_BINS        = 8192;
	localparam int MAX_PIXELS_LOG2 = 24;

	localparam int PIX_W      = 16;
	localparam int BIN_W      = $clog2(NUM_BINS);
	localparam int SCALE_LOG2 = PIX_W - BIN_W;
	localparam int CNT_W      = MAX_PIXELS_LOG2 + 1;
	localparam int SUM_W      = CNT_W + BIN_W;
	localparam int PROD_W     = CNT_W + SUM_W;
	localparam int NUM_W      = 2 * PROD_W;
	localparam int DEN_W      = 2 * CNT_W;
	localparam int CMP_W      = NUM_W + DEN_W;

	typedef logic [2:0] op_t;

	localparam op_t MUL_P = 3'd0;	// total * s_b
	localparam op_t MUL_Q = 3'd1;	// w_b * weighted sum
	localparam op_t MUL_N = 3'd2;	// diff * diff
	localparam op_t MUL_D = 3'd3;	// w_b * w_f
	localparam op_t MUL_L = 3'd4;	// num * max_den
	localparam op_t MUL_R = 3'd5;	// max_num * den

	typedef struct packed {
		logic ram_rd;
		logic rd_pix;
		logic wr_inc;
		logic wr_zero;
		logic pix_take;
		logic k_inc;
		logic k_dec;
		logic br_init;
		logic br_sub;
		logic br_done;
		logic scan_init;
		logic acc;
		logic hold_hit;
		logic mul_start;
		op_t  start_op;
		logic cap;
		op_t  cap_op;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic can_count;
		logic k_last;
		logic br_go;
		logic wf_zero;
		logic wb_zero;
		logic h_zero;
		logic mul_busy;
		logic mul_done;
		logic out_free;
	} sts_t;

endpackage

>>> sv/otsu_ram.sv
module otsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/otsu_mul.sv
module otsu_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [otsu_pkg::NUM_W-1:0]   a,
	input  logic [otsu_pkg::PROD_W-1:0]  b,
	output logic                         busy,
	output logic                         done,
	output logic [otsu_pkg::CMP_W-1:0]   prod
);
	import otsu_pkg::*;

	logic              busy_q;
	logic [CMP_W-1:0]  a_q;
	logic [PROD_W-1:0] b_q;
	logic [CMP_W-1:0]  acc_q;

	// shift-add, one multiplier bit per cycle; stop when no bits remain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= CMP_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = busy_q && (b_q == '0);
	assign prod = acc_q;

endmodule

>>> sv/otsu_dp.sv
module otsu_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  otsu_pkg::cmd_t              cmd,
	output otsu_pkg::sts_t              sts,
	input  logic [otsu_pkg::PIX_W-1:0]  pixel,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [otsu_pkg::PIX_W-1:0]  threshold,
	output logic [otsu_pkg::PIX_W-1:0]  bright_level
);
	import otsu_pkg::*;

	logic [BIN_W-1:0]  pix_bin;
	logic [BIN_W-1:0]  raddr;
	logic [BIN_W-1:0]  waddr;
	logic [CNT_W-1:0]  wdata;
	logic [CNT_W-1:0]  rd_data;

	logic [BIN_W-1:0]  k_q;
	logic [BIN_W-1:0]  bin_q;
	logic [CNT_W-1:0]  total_q;
	logic [SUM_W-1:0]  wsum_q;
	logic [CNT_W-1:0]  csum_q;
	logic [BIN_W-1:0]  bright_q;

	logic [CNT_W-1:0]  wb_q;
	logic [SUM_W-1:0]  sb_q;
	logic [CNT_W-1:0]  h_q;
	logic [PROD_W-1:0] p_q;
	logic [PROD_W-1:0] q_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [CMP_W-1:0]  lhs_q;
	logic [NUM_W-1:0]  max_num_q;
	logic [DEN_W-1:0]  max_den_q;
	logic [BIN_W-1:0]  t1_q;
	logic [BIN_W-1:0]  t2_q;
	logic              hit_q;

	logic [PIX_W-1:0]  thr_q;
	logic [PIX_W-1:0]  brt_q;
	logic              out_valid_q;

	logic [SUM_W-1:0]  kh;
	logic [CNT_W-1:0]  wf;
	logic [PROD_W-1:0] diff;
	logic [NUM_W-1:0]  mul_a;
	logic [PROD_W-1:0] mul_b;
	logic              mul_busy;
	logic              mul_done;
	logic [CMP_W-1:0]  prod;
	logic              ge;
	logic              gt;
	logic [CNT_W+1:0]  four_csum;
	logic [CNT_W+1:0]  three_total;
	logic [BIN_W:0]    t_sum;
	logic [PIX_W:0]    t_scaled;
	logic [PIX_W:0]    t_half;
	logic [PIX_W:0]    t_round;

	assign pix_bin = pixel[PIX_W-1 -: BIN_W];

	assign raddr = cmd.rd_pix ? pix_bin : k_q;
	assign waddr = cmd.wr_inc ? bin_q : k_q;
	assign wdata = cmd.wr_inc ? rd_data + CNT_W'(1) : '0;

	otsu_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_BINS)
	) u_hist (
		.clk  (clk),
		.we   (cmd.wr_inc | cmd.wr_zero),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.ram_rd),
		.raddr(raddr),
		.rdata(rd_data)
	);

	// bin index and frame totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			total_q <= '0;
			wsum_q  <= '0;
		end else begin
			if (cmd.scan_init) begin
				k_q <= '0;
			end else if (cmd.br_init) begin
				k_q <= '1;
			end else if (cmd.k_inc) begin
				k_q <= k_q + BIN_W'(1);
			end else if (cmd.k_dec) begin
				k_q <= k_q - BIN_W'(1);
			end
			if (cmd.out_load) begin
				total_q <= '0;
				wsum_q  <= '0;
			end else if (cmd.pix_take) begin
				total_q <= total_q + CNT_W'(1);
				wsum_q  <= wsum_q + SUM_W'(pix_bin);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_take) begin
			bin_q <= pix_bin;
		end
		if (cmd.br_init) begin
			csum_q <= total_q;
		end else if (cmd.br_sub) begin
			csum_q <= csum_q - rd_data;
		end
		if (cmd.br_done) begin
			bright_q <= k_q;
		end
	end

	assign four_csum   = (CNT_W+2)'(csum_q) << 2;
	assign three_total = (CNT_W+2)'(total_q) + ((CNT_W+2)'(total_q) << 1);

	// Otsu scan
	assign kh   = k_q * rd_data;
	assign wf   = total_q - wb_q;
	assign diff = (p_q >= q_q) ? p_q - q_q : q_q - p_q;
	assign ge   = lhs_q >= prod;
	assign gt   = lhs_q > prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.start_op)
			MUL_P: begin
				mul_a = NUM_W'(sb_q);
				mul_b = PROD_W'(total_q);
			end
			MUL_Q: begin
				mul_a = NUM_W'(wsum_q);
				mul_b = PROD_W'(wb_q);
			end
			MUL_N: begin
				mul_a = NUM_W'(diff);
				mul_b = diff;
			end
			MUL_D: begin
				mul_a = NUM_W'(wb_q);
				mul_b = PROD_W'(wf);
			end
			MUL_L: begin
				mul_a = num_q;
				mul_b = PROD_W'(max_den_q);
			end
			MUL_R: begin
				mul_a = max_num_q;
				mul_b = PROD_W'(den_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	otsu_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.busy  (mul_busy),
		.done  (mul_done),
		.prod  (prod)
	);

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			wb_q      <= '0;
			sb_q      <= '0;
			max_num_q <= '0;
			max_den_q <= DEN_W'(1);
			t1_q      <= '0;
			t2_q      <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (cmd.acc) begin
				h_q  <= rd_data;
				wb_q <= wb_q + rd_data;
				sb_q <= sb_q + kh;
			end
			// an empty bin repeats the previous variance
			if (cmd.hold_hit && hit_q) begin
				t1_q <= k_q;
			end
			if (cmd.cap) begin
				case (cmd.cap_op)
					MUL_P: p_q <= prod[PROD_W-1:0];
					MUL_Q: q_q <= prod[PROD_W-1:0];
					MUL_N: num_q <= prod[NUM_W-1:0];
					MUL_D: den_q <= prod[DEN_W-1:0];
					MUL_L: lhs_q <= prod;
					MUL_R: begin
						hit_q <= ge;
						if (ge) begin
							t1_q      <= k_q;
							max_num_q <= num_q;
							max_den_q <= den_q;
						end
						if (gt) begin
							t2_q <= k_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// (t1 + t2) * scale / 2, half to even
	assign t_sum    = (BIN_W+1)'(t1_q) + (BIN_W+1)'(t2_q);
	assign t_scaled = (PIX_W+1)'(t_sum) << SCALE_LOG2;
	assign t_half   = t_scaled >> 1;
	assign t_round  = t_half + (PIX_W+1)'(t_scaled[0] & t_half[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			thr_q <= t_round[PIX_W-1:0];
			brt_q <= PIX_W'(bright_q) << SCALE_LOG2;
		end
	end

	assign out_valid    = out_valid_q;
	assign threshold    = thr_q;
	assign bright_level = brt_q;

	assign sts.can_count = ~total_q[CNT_W-1];
	assign sts.k_last    = &k_q;
	assign sts.br_go     = (k_q != '0) && (four_csum > three_total);
	assign sts.wf_zero   = (total_q == wb_q);
	assign sts.wb_zero   = (wb_q == '0);
	assign sts.h_zero    = (h_q == '0);
	assign sts.mul_busy  = mul_busy;
	assign sts.mul_done  = mul_done;
	assign sts.out_free  = ~out_valid_q | out_ready;

endmodule

>>> sv/otsu_ctrl.sv
module otsu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last_pixel,
	output logic           in_ready,
	input  otsu_pkg::sts_t sts,
	output otsu_pkg::cmd_t cmd
);
	import otsu_pkg::*;

	localparam logic [3:0] S_CLR     = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_INC     = 4'd2;
	localparam logic [3:0] S_BR_CHK  = 4'd3;
	localparam logic [3:0] S_BR_SUB  = 4'd4;
	localparam logic [3:0] S_OT_RD   = 4'd5;
	localparam logic [3:0] S_OT_ACC  = 4'd6;
	localparam logic [3:0] S_OT_EVAL = 4'd7;
	localparam logic [3:0] S_MSTART  = 4'd8;
	localparam logic [3:0] S_MUL     = 4'd9;
	localparam logic [3:0] S_OT_NEXT = 4'd10;
	localparam logic [3:0] S_FIN     = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	op_t        op_q;
	op_t        op_d;
	logic       last_q;
	logic       last_d;
	logic       stop_q;
	logic       stop_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		op_d     = op_q;
		last_d   = last_q;
		stop_d   = stop_q;
		in_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.wr_zero = 1'b1;
				cmd.k_inc   = 1'b1;
				if (sts.k_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.can_count) begin
						cmd.ram_rd   = 1'b1;
						cmd.rd_pix   = 1'b1;
						cmd.pix_take = 1'b1;
						last_d       = last_pixel;
						state_d      = S_INC;
					end else if (last_pixel) begin
						cmd.br_init = 1'b1;
						state_d     = S_BR_CHK;
					end
				end
			end
			S_INC: begin
				cmd.wr_inc = 1'b1;
				if (last_q) begin
					cmd.br_init = 1'b1;
					state_d     = S_BR_CHK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_BR_CHK: begin
				if (sts.br_go) begin
					cmd.ram_rd = 1'b1;
					state_d    = S_BR_SUB;
				end else begin
					cmd.br_done   = 1'b1;
					cmd.scan_init = 1'b1;
					stop_d        = 1'b0;
					state_d       = S_OT_RD;
				end
			end
			S_BR_SUB: begin
				cmd.br_sub = 1'b1;
				cmd.k_dec  = 1'b1;
				state_d    = S_BR_CHK;
			end
			S_OT_RD: begin
				cmd.ram_rd = 1'b1;
				state_d    = S_OT_ACC;
			end
			S_OT_ACC: begin
				cmd.wr_zero = 1'b1;
				if (stop_q) begin
					state_d = S_OT_NEXT;
				end else begin
					cmd.acc = 1'b1;
					state_d = S_OT_EVAL;
				end
			end
			S_OT_EVAL: begin
				if (sts.wf_zero) begin
					stop_d  = 1'b1;
					state_d = S_OT_NEXT;
				end else if (sts.wb_zero) begin
					state_d = S_OT_NEXT;
				end else if (sts.h_zero) begin
					cmd.hold_hit = 1'b1;
					state_d      = S_OT_NEXT;
				end else begin
					op_d    = MUL_P;
					state_d = S_MSTART;
				end
			end
			S_MSTART: begin
				cmd.mul_start = 1'b1;
				cmd.start_op  = op_q;
				state_d       = S_MUL;
			end
			S_MUL: begin
				if (sts.mul_done) begin
					cmd.cap    = 1'b1;
					cmd.cap_op = op_q;
					if (op_q == MUL_R) begin
						state_d = S_OT_NEXT;
					end else begin
						op_d    = op_q + op_t'(1);
						state_d = S_MSTART;
					end
				end
			end
			S_OT_NEXT: begin
				cmd.k_inc = 1'b1;
				if (sts.k_last) begin
					state_d = S_FIN;
				end else begin
					state_d = S_OT_RD;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			op_q    <= MUL_P;
			last_q  <= 1'b0;
			stop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			last_q  <= last_d;
			stop_q  <= stop_d;
		end
	end

`ifndef SYNTHESIS
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !sts.mul_busy)
		else $error("multiplier started while busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an untaken result");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ram_rd |-> !(cmd.wr_inc || cmd.wr_zero))
		else $error("histogram read and write in one cycle");

	a_bin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cap && cmd.cap_op == MUL_R) |=> (state_q == S_OT_NEXT))
		else $error("scan did not advance after the compare");
`endif

endmodule

>>> sv/otsu_threshold_histogram_top.sv
// Otsu threshold over a streamed frame. Each accepted request carries one 16-bit pixel that is
// counted in the bin given by its top 13 bits (NUM_BINS = 8192 in otsu_pkg); a pixel
// takes a histogram read, then a write of the incremented count, and in_ready drops
// for the write. Once 2^MAX_PIXELS_LOG2 pixels are counted, further pixels are
// dropped. The request with last_pixel set closes the frame and starts the
// end-of-frame work, during which no pixel is taken: first a downward walk over
// the bins finds where the brightest quarter begins, then an upward sweep of every
// bin evaluates the exact between-class variance and zeroes the bin behind it. Each
// bin is read, accumulated and evaluated (accumulation and evaluation are skipped
// once the foreground has emptied); each bin with a nonzero count before the
// foreground empties also takes six passes of a shift-add multiplier (one
// multiplier bit per cycle). The result (threshold = (t1 + t2) * 4, bright_level =
// bin * 8) sits in an output register until taken; the next frame's pixels are
// accepted meanwhile. After reset the block zeroes every histogram bin before it
// takes its first pixel.
module otsu_threshold_histogram_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [otsu_pkg::PIX_W-1:0]  pixel,
	input  logic                        last_pixel,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [otsu_pkg::PIX_W-1:0]  threshold,
	output logic [otsu_pkg::PIX_W-1:0]  bright_level
);
	import otsu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing: histogram clearing, pixel counting, quarter walk, variance sweep, result hand-off
	otsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_pixel(last_pixel),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// histogram memory, running sums, multiplier and result registers
	otsu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.pixel       (pixel),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.threshold   (threshold),
		.bright_level(bright_level)
	);

endmodule

>>> tb/tb_otsu_threshold_histogram_top.sv
`timescale 1ns / 1ps

module tb_otsu_threshold_histogram_top;
	import otsu_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] value;
		logic             is_last;
	} pixel_req_t;

	typedef struct {
		logic [PIX_W-1:0] threshold;
		logic [PIX_W-1:0] bright_level;
	} frame_result_t;

	localparam int BIN_SCALE    = 1 << SCALE_LOG2;
	localparam longint PIX_CAP  = 64'd1 << MAX_PIXELS_LOG2;
	// Hold the result port this long so that two frame ends pile up behind it.
	localparam int HOLD_CYCLES  = 140000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [PIX_W-1:0]    pixel = '0;
	logic                last_pixel = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [PIX_W-1:0]    threshold;
	logic [PIX_W-1:0]    bright_level;

	pixel_req_t    pending_pixels[$];
	frame_result_t expected_results[$];

	// Predictor copy of the frame histogram.
	int unsigned     hist_count[NUM_BINS];
	longint unsigned frame_total;
	longint unsigned frame_bin_sum;

	int  error_count = 0;
	int  results_seen = 0;
	int  send_gap = 0;
	int  take_gap = 0;
	bit  burst_mode = 0;
	bit  hold_results = 0;

	otsu_threshold_histogram_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel        (pixel),
		.last_pixel   (last_pixel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.threshold    (threshold),
		.bright_level (bright_level)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	function automatic void clear_histogram();
		foreach (hist_count[i]) hist_count[i] = 0;
		frame_total   = 0;
		frame_bin_sum = 0;
	endfunction

	// Exact Otsu search; variances compared as cross-multiplied rationals.
	function automatic logic [PIX_W-1:0] otsu_level();
		logic [255:0]    p, q, diff, num, den, lhs, rhs, max_num, max_den;
		longint unsigned wb, sb, wf;
		int unsigned     t1, t2;
		wb = 0;
		sb = 0;
		t1 = 0;
		t2 = 0;
		max_num = 0;
		max_den = 1;
		for (int k = 0; k < NUM_BINS; k++) begin
			wb += hist_count[k];
			wf = frame_total - wb;
			if (wf == 0)
				break;
			sb += longint'(k) * hist_count[k];
			if (wb == 0)
				continue;
			p = 256'(frame_total) * 256'(sb);
			q = 256'(wb) * 256'(frame_bin_sum);
			diff = (p >= q) ? p - q : q - p;
			num = diff * diff;
			den = 256'(wb) * 256'(wf);
			lhs = num * max_den;
			rhs = max_num * den;
			if (lhs >= rhs) begin
				t1 = k;
				if (lhs > rhs)
					t2 = k;
				max_num = num;
				max_den = den;
			end
		end
		return PIX_W'(((t1 + t2) * BIN_SCALE) >> 1);
	endfunction

	// Walk down from the top bin until the brightest quarter is covered.
	function automatic logic [PIX_W-1:0] bright_start();
		longint unsigned csum;
		int              b;
		csum = frame_total;
		b = NUM_BINS - 1;
		while (b > 0 && 4 * csum > 3 * frame_total) begin
			csum -= hist_count[b];
			b--;
		end
		return PIX_W'(b * BIN_SCALE);
	endfunction

	function automatic void count_pixel(input pixel_req_t req);
		frame_result_t res;
		int            bin_idx;
		if (frame_total < PIX_CAP) begin
			bin_idx = int'(req.value >> SCALE_LOG2);
			hist_count[bin_idx]++;
			frame_total++;
			frame_bin_sum += bin_idx;
		end
		if (req.is_last) begin
			res.threshold    = otsu_level();
			res.bright_level = bright_start();
			expected_results = {expected_results, res};
			clear_histogram();
		end
	endfunction

	function automatic int draw_gap();
		return burst_mode ? 0 : $urandom_range(0, 12);
	endfunction

	// Request driver: count each accepted pixel, then offer the next one after its gap.
	always @(posedge clk or negedge arst_n) begin
		pixel_req_t req;
		pixel_req_t nxt;
		logic       stalled;
		logic       next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				req.value   = pixel;
				req.is_last = last_pixel;
				count_pixel(req);
			end
			stalled    = in_valid && !in_ready;
			next_valid = stalled;
			if (!stalled) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (pending_pixels.size() > 0) begin
					nxt = pending_pixels.pop_front();
					pixel      <= nxt.value;
					last_pixel <= nxt.is_last;
					next_valid = 1'b1;
					send_gap <= draw_gap();
					if ($urandom_range(0, 40) == 0)
						burst_mode <= !burst_mode;
				end
			end
			in_valid <= next_valid;
		end
	end

	// Result monitor: compare each taken result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		frame_result_t exp_res;
		logic          next_ready;
		if (!arst_n) begin
			out_ready <= 1'b0;
			take_gap  <= 0;
		end else begin
			next_ready = out_ready;
			if (out_valid && out_ready) begin
				results_seen++;
				next_ready = 1'b0;
				take_gap <= draw_gap();
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result thr=%0d bright=%0d",
						threshold, bright_level));
				end else begin
					exp_res = expected_results.pop_front();
					if (threshold !== exp_res.threshold)
						report_mismatch($sformatf("threshold got %0d want %0d",
							threshold, exp_res.threshold));
					if (bright_level !== exp_res.bright_level)
						report_mismatch($sformatf("bright_level got %0d want %0d",
							bright_level, exp_res.bright_level));
				end
			end else if (hold_results) begin
				next_ready = 1'b0;
			end else if (!out_ready) begin
				if (take_gap > 0)
					take_gap <= take_gap - 1;
				else
					next_ready = 1'b1;
			end
			out_ready <= next_ready;
		end
	end

	// Long hold-off on the result side once the stream is running.
	initial begin
		wait (results_seen >= 8);
		@(posedge clk);
		hold_results = 1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results = 0;
	end

	task automatic queue_pixel(input logic [PIX_W-1:0] value, input logic is_last);
		pixel_req_t req;
		req.value   = value;
		req.is_last = is_last;
		pending_pixels = {pending_pixels, req};
	endtask

	// Random frame: well-formed, with most levels drawn from four clusters so ties occur.
	task automatic queue_random_frame(input int len);
		logic [PIX_W-1:0] centers[4];
		int               spread;
		int               pick;
		spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 2000);
		foreach (centers[i]) centers[i] = PIX_W'($urandom);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 3);
			if ($urandom_range(0, 7) == 0)
				queue_pixel(PIX_W'($urandom), i == len - 1);
			else
				queue_pixel(PIX_W'(int'(centers[pick]) +
					$urandom_range(0, spread)), i == len - 1);
		end
	endtask

	initial begin
		int queued;
		int len;
		clear_histogram();

		// Extremes: lowest and highest pixel, each as a one-pixel frame.
		queue_pixel(16'h0000, 1'b1);
		queue_pixel(16'hFFFF, 1'b1);
		// All pixels in one bin: no variance evaluated.
		queue_pixel(16'h1238, 1'b0);
		queue_pixel(16'h123F, 1'b0);
		queue_pixel(16'h123A, 1'b1);
		// Two extremes, balanced so several bins tie on variance.
		queue_pixel(16'h0000, 1'b0);
		queue_pixel(16'hFFFF, 1'b0);
		queue_pixel(16'h0007, 1'b0);
		queue_pixel(16'hFFF8, 1'b1);
		// Unbalanced two-level frame and alternating bit patterns.
		queue_pixel(16'h5555, 1'b0);
		queue_pixel(16'hAAAA, 1'b0);
		queue_pixel(16'hAAAA, 1'b0);
		queue_pixel(16'hAAAA, 1'b1);
		// Four levels spread over the range.
		queue_pixel(16'h0010, 1'b0);
		queue_pixel(16'h8000, 1'b0);
		queue_pixel(16'h7FFF, 1'b0);
		queue_pixel(16'hFFF0, 1'b1);

		queued = 0;
		while (queued < 440) begin
			len = $urandom_range(1, 45);
			queue_random_frame(len);
			queued += len;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_pixels.size() == 0);
		@(posedge clk iff (in_valid && in_ready));
		@(posedge clk);
		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Each frame end walks down from the top bin, then sweeps every bin; allow many times the slowest run.
	initial begin
		#100ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
